>>> hdl/ngcb_pkg.sv
// ----------------------------------------------------------------------------
// ngcb_pkg: shared types and constants of the gear chunk boundary core
// Item layouts, register indexes and reset values.
// ----------------------------------------------------------------------------
package ngcb_pkg;

    localparam int LENGTH_BITS    = 18;
    localparam int TABLE_DEPTH    = 256;
    localparam int INDEX_BITS     = $clog2(TABLE_DEPTH);
    localparam int WORD_BITS      = 64;
    localparam int CFG_INDEX_BITS = 3;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SIZE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_SIZE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRICT_MASK = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOSE_MASK  = 3'd4;

    localparam logic [LENGTH_BITS-1:0] MIN_SIZE_RESET    = LENGTH_BITS'(4 * 1024);
    localparam logic [LENGTH_BITS-1:0] NORMAL_SIZE_RESET = LENGTH_BITS'(8 * 1024);
    localparam logic [LENGTH_BITS-1:0] MAX_SIZE_RESET    = LENGTH_BITS'(65536);
    localparam logic [WORD_BITS-1:0]   STRICT_MASK_RESET = 64'h0000_D930_0000_0000;
    localparam logic [WORD_BITS-1:0]   LOOSE_MASK_RESET  = 64'h0000_D903_0000_0000;

    // item kinds
    localparam logic KIND_TABLE = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [INDEX_BITS-1:0] table_index;
        logic [WORD_BITS-1:0]  table_word;
        logic [7:0]            data_byte;
        logic                  stream_end;
    } in_item_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] chunk_length;
        logic                   final_chunk;
    } out_item_t;

endpackage

>>> hdl/normalized_gear_chunk_boundary_core.sv
// ----------------------------------------------------------------------------
// normalized_gear_chunk_boundary_core: content-defined chunk boundary finder
// Runs a 64-bit gear fingerprint over a byte stream and reports chunk
// lengths, with a strict mask before normal_size and a loose one after.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | carries
//  ---------+------------------------------------------+------------------------
//  item     | item_valid, item_ready, item             | table word or data byte
//  result   | result_valid, result_ready, result       | chunk length, final flag
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| register writes
//
//  One item is taken per cycle unless processing stalls. The gear table read
//  is registered at the accept edge; the fingerprint update, mask test and
//  cut decision run when the processing stage fires and push up to two
//  results into a four-entry queue, valid from the edge at which the stage
//  fires. Reset clears the fingerprint, position and queue and presets the
//  registers; the gear table holds no reset value. The item side stalls only
//  while a processed item waits for two free queue slots.
// ----------------------------------------------------------------------------
module normalized_gear_chunk_boundary_core
    import ngcb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  in_item_t                  item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output out_item_t                 result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data
);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [LENGTH_BITS-1:0] min_size_reg;
    logic [LENGTH_BITS-1:0] normal_size_reg;
    logic [LENGTH_BITS-1:0] max_size_reg;
    logic [WORD_BITS-1:0]   strict_mask_reg;
    logic [WORD_BITS-1:0]   loose_mask_reg;

    // gear table
    logic [WORD_BITS-1:0] gear_mem [TABLE_DEPTH];
    logic [WORD_BITS-1:0] gear_rd_reg;

    // processing stage
    logic                   s1_valid_reg;
    logic                   s1_kind_reg;
    logic                   s1_end_reg;
    logic                   s1_fire;
    logic                   item_accept;

    // chunk state
    logic [WORD_BITS-1:0]   fp_reg;
    logic [WORD_BITS-1:0]   fp_next;
    logic [LENGTH_BITS-1:0] pos_reg;
    logic [LENGTH_BITS-1:0] pos_next;

    // result queue
    out_item_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   head_reg;
    logic [QPTR_BITS-1:0]   tail_reg;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;

    // combinational step
    logic [LENGTH_BITS-1:0] start_pos;
    logic                   do_fp;
    logic [WORD_BITS-1:0]   mask;
    logic [WORD_BITS-1:0]   fp_mixed;
    logic                   match;
    logic [LENGTH_BITS-1:0] pos_after;
    logic [WORD_BITS-1:0]   fp_after;
    logic                   cut;
    logic                   push_a;
    logic                   push_b;
    out_item_t              res_a;
    out_item_t              res_b;
    logic                   pop;

    assign cfg_ready    = 1'b1;
    assign s1_fire      = s1_valid_reg && (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign item_ready   = !s1_valid_reg || s1_fire;
    assign item_accept  = item_valid && item_ready;
    assign result_valid = (count_reg != '0);
    assign result       = queue_reg[head_reg];
    assign pop          = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg    <= MIN_SIZE_RESET;
            normal_size_reg <= NORMAL_SIZE_RESET;
            max_size_reg    <= MAX_SIZE_RESET;
            strict_mask_reg <= STRICT_MASK_RESET;
            loose_mask_reg  <= LOOSE_MASK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_SIZE:    min_size_reg    <= cfg_data[LENGTH_BITS-1:0];
                REG_NORMAL_SIZE: normal_size_reg <= cfg_data[LENGTH_BITS-1:0];
                REG_MAX_SIZE:    max_size_reg    <= cfg_data[LENGTH_BITS-1:0];
                REG_STRICT_MASK: strict_mask_reg <= cfg_data;
                REG_LOOSE_MASK:  loose_mask_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // write table words, read the gear entry of each data byte at accept
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            if (item.kind == KIND_TABLE)
            begin
                gear_mem[item.table_index] <= item.table_word;
            end
            else
            begin
                gear_rd_reg <= gear_mem[item.data_byte];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_TABLE;
            s1_end_reg   <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
            if (item_valid)
            begin
                s1_kind_reg <= item.kind;
                s1_end_reg  <= item.stream_end;
            end
        end
    end

    always_comb
    begin
        start_pos = (min_size_reg == '0) ? LENGTH_BITS'(1) : min_size_reg;
        do_fp     = (pos_reg >= start_pos);
        mask      = (pos_reg < normal_size_reg) ? strict_mask_reg : loose_mask_reg;
        fp_mixed  = {fp_reg[WORD_BITS-2:0], 1'b0} + gear_rd_reg;
        match     = do_fp && ((fp_mixed & mask) == '0);
        // a match restarts the count with the current byte as first of the next chunk
        pos_after = match ? LENGTH_BITS'(1) : pos_reg + LENGTH_BITS'(1);
        fp_after  = match ? '0 : (do_fp ? fp_mixed : fp_reg);
        cut       = (pos_after >= max_size_reg) || s1_end_reg;

        res_a.chunk_length = pos_reg;
        res_a.final_chunk  = 1'b0;
        res_b.chunk_length = pos_after;
        res_b.final_chunk  = s1_end_reg;

        push_a = s1_fire && (s1_kind_reg == KIND_DATA) && match;
        push_b = s1_fire && (s1_kind_reg == KIND_DATA) && cut;

        pos_next = pos_reg;
        fp_next  = fp_reg;
        if (s1_fire && (s1_kind_reg == KIND_DATA))
        begin
            pos_next = cut ? '0 : pos_after;
            fp_next  = cut ? '0 : fp_after;
        end

        count_next = count_reg + QCNT_BITS'(push_a) + QCNT_BITS'(push_b) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg    <= '0;
            pos_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            fp_reg    <= fp_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            if (pop)
            begin
                head_reg <= head_reg + QPTR_BITS'(1);
            end
            tail_reg <= tail_reg + QPTR_BITS'(push_a) + QPTR_BITS'(push_b);
        end
    end

    // queue slots, match cut first, then the length or end cut
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            queue_reg[tail_reg] <= res_a;
            if (push_b)
            begin
                queue_reg[tail_reg + QPTR_BITS'(1)] <= res_b;
            end
        end
        else if (push_b)
        begin
            queue_reg[tail_reg] <= res_b;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> s1_valid_reg)
        else $error("accepted item did not reach the processing stage");

    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (count_reg >= $past(count_reg)))
        else $error("queued result dropped while output stalled");

endmodule

>>> verif/normalized_gear_chunk_boundary_core_tb.sv
// ----------------------------------------------------------------------------
// normalized_gear_chunk_boundary_core_tb: self-checking bench for the core
// Loads the gear table, runs a short directed set of cases on the chunk
// size and mask settings, then random byte streams across many register
// settings. The bench predicts chunk lengths from its own model of the
// fingerprint and cut rules, and checks each result item in order.
// ----------------------------------------------------------------------------
module normalized_gear_chunk_boundary_core_tb
    import ngcb_pkg::*;
;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SETTLE_GAP   = 8;
    localparam int MAX_REPORTS  = 20;
    localparam int SIZE_TOP     = 131072;

    // Chunk length predictor and store of expected chunks
    class chunk_tracker;
        logic [LENGTH_BITS-1:0] min_size;
        logic [LENGTH_BITS-1:0] normal_size;
        logic [LENGTH_BITS-1:0] max_size;
        logic [WORD_BITS-1:0]   strict_mask;
        logic [WORD_BITS-1:0]   loose_mask;
        logic [WORD_BITS-1:0]   gear [TABLE_DEPTH];
        logic [WORD_BITS-1:0]   fingerprint;
        logic [LENGTH_BITS-1:0] position;
        out_item_t              pending_chunks [$];
        int                     mismatches;

        function new();
            min_size    = MIN_SIZE_RESET;
            normal_size = NORMAL_SIZE_RESET;
            max_size    = MAX_SIZE_RESET;
            strict_mask = STRICT_MASK_RESET;
            loose_mask  = LOOSE_MASK_RESET;
            fingerprint = '0;
            position    = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
            case (idx)
                REG_MIN_SIZE:    min_size    = data[LENGTH_BITS-1:0];
                REG_NORMAL_SIZE: normal_size = data[LENGTH_BITS-1:0];
                REG_MAX_SIZE:    max_size    = data[LENGTH_BITS-1:0];
                REG_STRICT_MASK: strict_mask = data;
                REG_LOOSE_MASK:  loose_mask  = data;
                default: ;
            endcase
        endfunction

        function void close_chunk(logic [LENGTH_BITS-1:0] len, logic fin);
            out_item_t r;
            r.chunk_length = len;
            r.final_chunk  = fin;
            pending_chunks.push_back(r);
            fingerprint = '0;
        endfunction

        function void take_item(in_item_t x);
            logic [LENGTH_BITS-1:0] start;
            logic [LENGTH_BITS-1:0] pos;
            logic [WORD_BITS-1:0]   mask;
            if (x.kind == KIND_TABLE)
            begin
                gear[x.table_index] = x.table_word;
                return;
            end
            start = (min_size == '0) ? LENGTH_BITS'(1) : min_size;
            pos   = position;
            if (pos >= start)
            begin
                mask = (pos < normal_size) ? strict_mask : loose_mask;
                fingerprint = (fingerprint << 1) + gear[x.data_byte];
                // cut before this byte; it opens the next chunk
                if ((fingerprint & mask) == '0)
                begin
                    close_chunk(pos, 1'b0);
                    pos = '0;
                end
            end
            pos = pos + LENGTH_BITS'(1);
            if (pos >= max_size || x.stream_end)
            begin
                close_chunk(pos, x.stream_end);
                pos = '0;
            end
            position = pos;
        endfunction

        function void check_chunk(out_item_t got);
            out_item_t want;
            if (pending_chunks.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected chunk: expected none, got length %0d final %0b",
                             $time, got.chunk_length, got.final_chunk);
                mismatches++;
                return;
            end
            want = pending_chunks.pop_front();
            if (got.chunk_length !== want.chunk_length)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: chunk_length mismatch: expected %0d, got %0d",
                             $time, want.chunk_length, got.chunk_length);
                mismatches++;
            end
            if (got.final_chunk !== want.final_chunk)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: final_chunk mismatch: expected %0b, got %0b",
                             $time, want.final_chunk, got.final_chunk);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    in_item_t                  item;
    logic                      result_valid;
    logic                      result_ready;
    out_item_t                 result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0]      cfg_data;

    chunk_tracker tracker;
    int           burst_left;
    int           items_sent;
    int           stall_left;
    int           quiet_cycles;
    bit           tx_calm;
    bit           rx_calm;

    normalized_gear_chunk_boundary_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls unless told to stay calm
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!rx_calm && $urandom_range(0, 3) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (item_valid && item_ready)
                tracker.take_item(item);
            if (result_valid && result_ready)
                tracker.check_chunk(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("normalized_gear_chunk_boundary_core_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input in_item_t x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = tx_calm ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        items_sent++;
        item       <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic send_data(input logic [7:0] b, input logic last);
        in_item_t x;
        x.kind        = KIND_DATA;
        x.table_index = INDEX_BITS'($urandom);
        x.table_word  = {$urandom, $urandom};
        x.data_byte   = b;
        x.stream_end  = last;
        send_item(x);
    endtask

    task automatic send_table(input logic [INDEX_BITS-1:0] idx, input logic [WORD_BITS-1:0] w,
                              input logic last);
        in_item_t x;
        x.kind        = KIND_TABLE;
        x.table_index = idx;
        x.table_word  = w;
        x.data_byte   = 8'($urandom);
        x.stream_end  = last;
        send_item(x);
    endtask

    // hold until every expected chunk is in, then let the pipeline empty
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_chunks.size() != 0) @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
        burst_left = 0;
    endtask

    // drop valid for a cycle after each write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [WORD_BITS-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int min_v, input int norm_v, input int max_v,
                             input logic [WORD_BITS-1:0] strict_v,
                             input logic [WORD_BITS-1:0] loose_v);
        write_reg(REG_MIN_SIZE, WORD_BITS'(min_v));
        write_reg(REG_NORMAL_SIZE, WORD_BITS'(norm_v));
        write_reg(REG_MAX_SIZE, WORD_BITS'(max_v));
        write_reg(REG_STRICT_MASK, strict_v);
        write_reg(REG_LOOSE_MASK, loose_v);
    endtask

    // few set bits give frequent matches; zero and all ones are the extremes
    function automatic logic [WORD_BITS-1:0] pick_mask();
        logic [WORD_BITS-1:0] m;
        int                   sel;
        m   = '0;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            m = '1;
        else if (sel == 1)
            m = {$urandom, $urandom};
        else if (sel != 2)
            repeat ($urandom_range(1, 3)) m[6'($urandom_range(0, WORD_BITS - 1))] = 1'b1;
        return m;
    endfunction

    task automatic send_stream(input int len);
        bit close;
        close = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_table(INDEX_BITS'($urandom), {$urandom, $urandom},
                           1'($urandom_range(0, 1)));
            if (i == len - 1)
                send_data(8'($urandom), close);
            else
                send_data(8'($urandom), $urandom_range(0, 63) == 0);
        end
    endtask

    initial
    begin
        int len;
        int target;
        int min_v;
        int norm_v;
        int max_v;
        tracker      = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        burst_left   = 0;
        items_sent   = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole gear table so no byte reads an unwritten entry
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_table(INDEX_BITS'(i), {$urandom, $urandom}, 1'($urandom_range(0, 1)));

        // reset sizes: a short stream never reaches fingerprinting
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'h5A, 1'b1);
        // table write ignores the end flag
        send_table(8'hFF, '1, 1'b1);
        settle();

        // zero min size acts as one; zero masks match every fingerprinted byte,
        // so the final byte both matches and ends the stream
        configure(0, 1, SIZE_TOP, '0, '0);
        send_data(8'h01, 1'b0);
        send_data(8'h80, 1'b0);
        send_data(8'h7F, 1'b1);
        settle();

        // tiny max size cuts after every byte
        write_reg(REG_MAX_SIZE, WORD_BITS'(0));
        send_data(8'h33, 1'b0);
        send_data(8'hCC, 1'b0);
        settle();
        write_reg(REG_MAX_SIZE, WORD_BITS'(1));
        send_data(8'h0F, 1'b0);
        send_data(8'hF0, 1'b1);
        settle();

        // max size below min size: forced cuts only
        configure(20, SIZE_TOP, 5, '1, '1);
        repeat (5) send_data(8'($urandom), 1'b0);
        send_data(8'($urandom), 1'b1);
        settle();

        configure(SIZE_TOP, SIZE_TOP, SIZE_TOP, '1, '0);
        send_data(8'($urandom), 1'b0);
        send_data(8'($urandom), 1'b0);
        send_data(8'($urandom), 1'b1);
        settle();

        // strict mask never matches, loose mask always does
        configure(2, 4, SIZE_TOP, '1, '0);
        repeat (4) send_data(8'($urandom), 1'b0);
        send_data(8'($urandom), 1'b1);
        settle();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            min_v   = $urandom_range(0, 10);
            norm_v  = $urandom_range(0, 20);
            max_v   = $urandom_range(0, 48);
            case ($urandom_range(0, 7))
                0: max_v  = SIZE_TOP;
                1: min_v  = SIZE_TOP;
                2: max_v  = $urandom_range(0, 1);
                3: norm_v = SIZE_TOP;
                default: ;
            endcase
            configure(min_v, norm_v, max_v, pick_mask(), pick_mask());
            target = items_sent + $urandom_range(60, 160);
            while (items_sent < target)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 150)
                                                  : $urandom_range(1, 40);
                send_stream(len);
            end
            settle();
        end

        if (tracker.mismatches == 0 && tracker.pending_chunks.size() == 0)
            $display("normalized_gear_chunk_boundary_core_tb OK");
        else
            $display("normalized_gear_chunk_boundary_core_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hdl/ngcb_pkg.sv
hdl/normalized_gear_chunk_boundary_core.sv
verif/normalized_gear_chunk_boundary_core_tb.sv
